// ===== rtl/clock_multiplier_x24_defines.svh =====
// Assertion macros used by the clock multiplier beat core.
`ifndef CLOCK_MULTIPLIER_X24_DEFINES_SVH
`define CLOCK_MULTIPLIER_X24_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CM24_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cm24: invariant violated");

// A condition that must hold in the same cycle whenever the trigger is true.
`define CM24_ASSERT_IMP(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("cm24: implication violated");

`endif

// ===== rtl/cm24_pkg.sv =====
// Package with shared constants and payload types of the clock multiplier.
package cm24_pkg;

  // Default counter width and multiplication ratio.
  localparam int COUNT_WIDTH_DEF = 20;
  localparam int RATIO_DEF       = 24;

  // Minimum pulse width register.
  localparam int                      MIN_PW_WIDTH = 8;
  localparam logic [MIN_PW_WIDTH-1:0] MIN_PW_RESET = 8'd10;

  // One timer tick as sampled at the inputs.
  typedef struct packed {
    logic clock_level;
    logic resync_level;
  } tick_t;

  // Output levels after one tick.
  typedef struct packed {
    logic out_x1;
    logic out_x24;
    logic led;
  } levels_t;

endpackage

// ===== rtl/cm24_tick_if.sv =====
// Handshake channel that carries one timer tick request.
interface cm24_tick_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic resync_level;

  modport source (output valid, output clock_level, output resync_level, input ready);
  modport sink   (input valid, input clock_level, input resync_level, output ready);
endinterface

// ===== rtl/cm24_level_if.sv =====
// Handshake channel that carries one request of output levels.
interface cm24_level_if;
  logic valid;
  logic ready;
  logic out_x1;
  logic out_x24;
  logic led;

  modport source (output valid, output out_x1, output out_x24, output led, input ready);
  modport sink   (input valid, input out_x1, input out_x24, input led, output ready);
endinterface

// ===== rtl/cm24_edge_count.sv =====
// Edge interval counter that also tracks its own quotient and remainder by the ratio.
module cm24_edge_count
  import cm24_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int RATIO       = RATIO_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   restart,
  output logic [COUNT_WIDTH-1:0] ticks_inc,
  output logic [COUNT_WIDTH-1:0] quot_inc
);

  localparam int                     REM_WIDTH = $clog2(RATIO);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [REM_WIDTH-1:0]   REM_LAST  = REM_WIDTH'(RATIO - 1);

  logic [COUNT_WIDTH-1:0] ticks;
  logic [COUNT_WIDTH-1:0] quot;
  logic [REM_WIDTH-1:0]   rem;
  logic [REM_WIDTH-1:0]   rem_inc;
  logic                   saturated;

  // Saturating increment; the quotient steps whenever the remainder wraps.
  always_comb begin
    saturated = (ticks == CNT_MAX);
    ticks_inc = ticks;
    quot_inc  = quot;
    rem_inc   = rem;
    if (!saturated) begin
      ticks_inc = ticks + 1'b1;
      if (rem == REM_LAST) begin
        rem_inc  = '0;
        quot_inc = quot + 1'b1;
      end else begin
        rem_inc = rem + 1'b1;
      end
    end
  end

  // Counter registers advance once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '0;
      quot  <= '0;
      rem   <= '0;
    end else if (advance) begin
      if (restart) begin
        ticks <= '0;
        quot  <= '0;
        rem   <= '0;
      end else begin
        ticks <= ticks_inc;
        quot  <= quot_inc;
        rem   <= rem_inc;
      end
    end
  end

endmodule

// ===== rtl/cm24_beat_core.sv =====
// Beat detection, period bookkeeping and pulse generation for one tick.
`include "clock_multiplier_x24_defines.svh"

module cm24_beat_core
  import cm24_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int RATIO       = RATIO_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  tick_t                   item,
  input  logic [MIN_PW_WIDTH-1:0] min_pw,
  output levels_t                 result
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Tick state.
  logic [COUNT_WIDTH-1:0] beat_ticks, x1_ticks, x24_ticks;
  logic [COUNT_WIDTH-1:0] captured_period, captured_q;
  logic [COUNT_WIDTH-1:0] period_x1, period_q, width_x1, width_x24;
  logic                   prev_clock, prev_resync, level_x1, level_x24;

  // Next values.
  logic [COUNT_WIDTH-1:0] beat_ticks_next, x1_ticks_next, x24_ticks_next;
  logic [COUNT_WIDTH-1:0] captured_period_next, captured_q_next;
  logic [COUNT_WIDTH-1:0] period_x1_next, period_q_next, width_x1_next, width_x24_next;
  logic                   level_x1_next, level_x24_next;

  logic [COUNT_WIDTH-1:0] edge_inc, edge_q_inc;
  logic [COUNT_WIDTH-1:0] half_x1, half_x24, min_ext;
  logic [COUNT_WIDTH:0]   min_plus1;
  logic                   clock_rise, resync_rise, beat;

  assign clock_rise  = item.clock_level & ~prev_clock;
  assign resync_rise = item.resync_level & ~prev_resync;

  cm24_edge_count #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .RATIO       (RATIO)
  ) u_edge (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .restart   (clock_rise),
    .ticks_inc (edge_inc),
    .quot_inc  (edge_q_inc)
  );

  // One tick: count, capture, beat, retrigger and fall.
  always_comb begin
    min_ext   = COUNT_WIDTH'(min_pw);
    min_plus1 = (COUNT_WIDTH + 1)'(min_pw) + 1'b1;

    beat_ticks_next = (beat_ticks == CNT_MAX) ? beat_ticks : beat_ticks + 1'b1;
    x1_ticks_next   = (x1_ticks == CNT_MAX) ? x1_ticks : x1_ticks + 1'b1;
    x24_ticks_next  = (x24_ticks == CNT_MAX) ? x24_ticks : x24_ticks + 1'b1;

    captured_period_next = captured_period;
    captured_q_next      = captured_q;
    if (clock_rise) begin
      captured_period_next = edge_inc;
      captured_q_next      = edge_q_inc;
      beat_ticks_next      = '0;
    end

    level_x1_next  = level_x1 | resync_rise;
    level_x24_next = level_x24 | resync_rise;

    period_x1_next = period_x1;
    period_q_next  = period_q;
    width_x1_next  = width_x1;
    width_x24_next = width_x24;
    half_x1        = '0;
    half_x24       = '0;

    beat = (beat_ticks_next >= period_x1) ||
           ((captured_period_next != '0) && item.clock_level);
    if (beat) begin
      if (captured_period_next == '0) begin
        if (beat_ticks_next > period_x1) begin
          beat_ticks_next = beat_ticks_next - period_x1;
        end
      end else begin
        period_x1_next       = captured_period_next;
        period_q_next        = captured_q_next;
        captured_period_next = '0;
        captured_q_next      = '0;
      end
      x1_ticks_next  = '0;
      x24_ticks_next = '0;
      level_x1_next  = 1'b1;
      level_x24_next = 1'b1;

      // The x24 half width is the quotient halved: floor(p / 2R).
      half_x1  = period_x1_next >> 1;
      half_x24 = period_q_next >> 1;
      width_x1_next  = half_x1;
      width_x24_next = half_x24;
      if (({1'b0, period_x1_next} > min_plus1) && (half_x1 < min_ext)) begin
        width_x1_next = min_ext;
      end
      if (({1'b0, period_q_next} > min_plus1) && (half_x24 < min_ext)) begin
        width_x24_next = min_ext;
      end
    end

    // Retrigger on the period.
    if (x1_ticks_next >= period_x1_next) begin
      x1_ticks_next = '0;
      level_x1_next = 1'b1;
    end
    if (x24_ticks_next >= period_q_next) begin
      x24_ticks_next = '0;
      level_x24_next = 1'b1;
    end

    // Fall after the width.
    if (x1_ticks_next >= width_x1_next) begin
      level_x1_next = 1'b0;
    end
    if (x24_ticks_next >= width_x24_next) begin
      level_x24_next = 1'b0;
    end

    result.out_x1  = level_x1_next;
    result.out_x24 = level_x24_next;
    result.led     = item.clock_level;
  end

  // State registers update once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_ticks      <= '0;
      x1_ticks        <= '0;
      x24_ticks       <= '0;
      captured_period <= '0;
      captured_q      <= '0;
      period_x1       <= '0;
      period_q        <= '0;
      width_x1        <= '0;
      width_x24       <= '0;
      prev_clock      <= 1'b0;
      prev_resync     <= 1'b0;
      level_x1        <= 1'b0;
      level_x24       <= 1'b0;
    end else if (advance) begin
      beat_ticks      <= beat_ticks_next;
      x1_ticks        <= x1_ticks_next;
      x24_ticks       <= x24_ticks_next;
      captured_period <= captured_period_next;
      captured_q      <= captured_q_next;
      period_x1       <= period_x1_next;
      period_q        <= period_q_next;
      width_x1        <= width_x1_next;
      width_x24       <= width_x24_next;
      prev_clock      <= item.clock_level;
      prev_resync     <= item.resync_level;
      level_x1        <= level_x1_next;
      level_x24       <= level_x24_next;
    end
  end

  // The stored quotients must always match their periods, and widths never fall below half their periods.
  `CM24_ASSERT(a_period_quot, (longint'(period_q) * RATIO <= longint'(period_x1)) && (longint'(period_x1) - longint'(period_q) * RATIO < RATIO))
  `CM24_ASSERT_IMP(a_captured_quot, captured_period != '0, (longint'(captured_q) * RATIO <= longint'(captured_period)) && (longint'(captured_period) - longint'(captured_q) * RATIO < RATIO))
  `CM24_ASSERT(a_width_x1_floor, width_x1 >= (period_x1 >> 1))
  `CM24_ASSERT(a_width_x24_floor, width_x24 >= (period_q >> 1))

endmodule

// ===== rtl/clock_multiplier_x24.sv =====
// Top level of the tick-based x1 / x24 clock multiplier.
//
// Each tick request carries the clock and resync levels sampled at one timer
// tick; each tick yields exactly one request of output levels (x1, x24, led).
// One tick is taken every cycle unless the level receiver stalls: a tick is held
// in an input register, processed in a single pass through the beat logic, and
// its levels leave from an output register. The divide-by-ratio for the x24
// period is tracked incrementally alongside the edge counter, so no divider is on
// the path. Counters are COUNT_WIDTH bits and saturate. min_pulse_width resets
// to 10 and should be written only while no tick is in flight.
module clock_multiplier_x24
  import cm24_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int RATIO       = RATIO_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [MIN_PW_WIDTH-1:0] cfg_wr_data,
  cm24_tick_if.sink               ticks,
  cm24_level_if.source            levels
);

  logic [MIN_PW_WIDTH-1:0] min_pw;
  logic                    in_valid;
  tick_t                   in_item;
  logic                    out_valid;
  levels_t                 out_item;
  levels_t                 result;
  logic                    advance;

  // A tick moves on whenever the output register is free or being emptied.
  assign advance     = in_valid && (!out_valid || levels.ready);
  assign ticks.ready = !in_valid || advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pw <= MIN_PW_RESET;
    end else if (cfg_wr_en) begin
      min_pw <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ticks.ready) begin
      in_valid <= ticks.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ticks.valid && ticks.ready) begin
      in_item.clock_level  <= ticks.clock_level;
      in_item.resync_level <= ticks.resync_level;
    end
  end

  cm24_beat_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .RATIO       (RATIO)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .min_pw  (min_pw),
    .result  (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign levels.valid   = out_valid;
  assign levels.out_x1  = out_item.out_x1;
  assign levels.out_x24 = out_item.out_x24;
  assign levels.led     = out_item.led;

endmodule

// ===== test/tb_clock_multiplier_x24.sv =====
// Self-checking testbench for the tick-based x1 / x24 clock multiplier.
import cm24_pkg::*;

// Tracks the multiplier state per tick and checks every returned level request.
class multiplier_levels_sb;
  typedef logic [COUNT_WIDTH_DEF-1:0] count_t;

  logic [MIN_PW_WIDTH-1:0] min_width = MIN_PW_RESET;

  count_t edge_ticks     = '0;
  count_t beat_ticks     = '0;
  count_t x1_ticks       = '0;
  count_t x24_ticks      = '0;
  count_t pending_period = '0;
  count_t period_x1      = '0;
  count_t period_x24     = '0;
  count_t width_x1       = '0;
  count_t width_x24      = '0;
  bit     last_clock     = 1'b0;
  bit     last_resync    = 1'b0;
  bit     lvl_x1         = 1'b0;
  bit     lvl_x24        = 1'b0;

  levels_t expected_levels[$];
  int      mismatch_count = 0;
  int      checked_count  = 0;

  // Tick counters stop at all ones instead of wrapping.
  function count_t bump(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // A beat restarts both outputs and recomputes periods and widths.
  function void fire_beat();
    int unsigned m;
    m = 32'(min_width);
    if (pending_period == '0) begin
      if (beat_ticks > period_x1) beat_ticks = beat_ticks - period_x1;
    end else begin
      period_x1      = pending_period;
      pending_period = '0;
    end
    x1_ticks  = '0;
    x24_ticks = '0;
    lvl_x1    = 1'b1;
    lvl_x24   = 1'b1;

    width_x1   = period_x1 >> 1;
    width_x24  = count_t'(width_x1 / RATIO_DEF);
    period_x24 = count_t'(period_x1 / RATIO_DEF);

    // Widths are stretched to the minimum only when the period has room.
    if (period_x1 > m + 1 && width_x1 < m) width_x1 = count_t'(m);
    if (period_x24 > m + 1 && width_x24 < m) width_x24 = count_t'(m);
  endfunction

  // Notes one accepted tick and queues the levels it must produce.
  function void note_tick(bit clock, bit resync);
    bit      beat_now;
    levels_t want;
    edge_ticks = bump(edge_ticks);
    beat_ticks = bump(beat_ticks);
    x1_ticks   = bump(x1_ticks);
    x24_ticks  = bump(x24_ticks);

    // A rising clock edge captures the period and restarts edge and beat counts.
    if (clock && !last_clock) begin
      pending_period = edge_ticks;
      edge_ticks     = '0;
      beat_ticks     = '0;
    end

    // A resync edge only raises the levels.
    if (resync && !last_resync) begin
      lvl_x1  = 1'b1;
      lvl_x24 = 1'b1;
    end

    beat_now = (beat_ticks >= period_x1);
    if (beat_now || (pending_period != '0 && clock)) fire_beat();

    // Retrigger on the period, then fall once the width has passed.
    if (x1_ticks >= period_x1) begin
      x1_ticks = '0;
      lvl_x1   = 1'b1;
    end
    if (x24_ticks >= period_x24) begin
      x24_ticks = '0;
      lvl_x24   = 1'b1;
    end
    if (x1_ticks >= width_x1) lvl_x1 = 1'b0;
    if (x24_ticks >= width_x24) lvl_x24 = 1'b0;

    last_clock  = clock;
    last_resync = resync;

    want.out_x1  = lvl_x1;
    want.out_x24 = lvl_x24;
    want.led     = clock;
    expected_levels.push_back(want);
  endfunction

  // Prints one line per mismatch and counts it.
  task report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at result %0d: %s", checked_count, what);
  endtask

  // Compares one accepted level request with the oldest expectation.
  task check_levels(levels_t got);
    levels_t want;
    checked_count++;
    if (expected_levels.size() == 0) begin
      report_mismatch("level request with no tick outstanding");
      return;
    end
    want = expected_levels.pop_front();
    if (got.out_x1 !== want.out_x1)
      report_mismatch($sformatf("out_x1 got %b want %b", got.out_x1, want.out_x1));
    if (got.out_x24 !== want.out_x24)
      report_mismatch($sformatf("out_x24 got %b want %b", got.out_x24, want.out_x24));
    if (got.led !== want.led)
      report_mismatch($sformatf("led got %b want %b", got.led, want.led));
  endtask
endclass

module tb_clock_multiplier_x24;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 22;
  localparam int LONG_HOLD    = 90;
  localparam int SETTLE       = 6;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [MIN_PW_WIDTH-1:0] cfg_wr_data;

  bit gaps_on   = 1'b1;
  bit hold_req  = 1'b0;
  bit resync_lv = 1'b0;

  cm24_tick_if  tick_ch ();
  cm24_level_if level_ch ();

  multiplier_levels_sb sb = new();

  clock_multiplier_x24 uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .ticks      (tick_ch),
    .levels     (level_ch)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both handshakes are observed at the same edge so notes always precede checks.
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready)
        sb.note_tick(tick_ch.clock_level, tick_ch.resync_level);
      if (level_ch.valid && level_ch.ready)
        sb.check_levels('{out_x1: level_ch.out_x1, out_x24: level_ch.out_x24,
                          led: level_ch.led});
    end
  end

  // Receiver side: random stalls, plus one long hold-off when asked.
  initial begin
    level_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        level_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      level_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      @(posedge clk);
    end
  end

  // Offers one tick request, with random idle cycles ahead of it.
  task automatic send_tick(bit clock, bit resync);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.clock_level  <= clock;
    tick_ch.resync_level <= resync;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // Lowers valid and waits until every tick has returned its levels.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the minimum pulse width while the block is idle.
  task automatic write_min_width(logic [MIN_PW_WIDTH-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sb.min_width = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Resync toggles now and then, independent of the clock input.
  task automatic send_with_resync(bit clock);
    if ($urandom_range(0, 99) < 6) resync_lv = ~resync_lv;
    send_tick(clock, resync_lv);
  endtask

  // Mostly regular clock waveforms, some dropouts and some random noise.
  // A phase sends exactly n_ticks requests.
  task automatic run_clock_phase(int n_ticks);
    int sent;
    int kind;
    int period;
    int high_len;
    int reps;
    sent = 0;
    while (sent < n_ticks) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) period = $urandom_range(2, 40);
        else if (kind < 90) period = $urandom_range(41, 160);
        else period = $urandom_range(161, 320);
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          high_len = $urandom_range(1, period - 1);
          for (int i = 0; i < period && sent < n_ticks; i++) begin
            send_with_resync(i < high_len);
            sent++;
          end
        end
      end else if (kind < 85) begin
        // The clock stops; the internal beat has to carry on.
        reps = $urandom_range(5, 80);
        repeat (reps) begin
          if (sent < n_ticks) begin
            send_with_resync(1'b0);
            sent++;
          end
        end
      end else begin
        reps = $urandom_range(3, 20);
        repeat (reps) begin
          if (sent < n_ticks) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
          end
        end
      end
    end
  endtask

  // Main sequence: reset, directed ticks, then random phases per setting.
  initial begin
    logic [MIN_PW_WIDTH-1:0] widths[8];
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.clock_level  <= 1'b0;
    tick_ch.resync_level <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero period after reset: a beat every tick with zero-width outputs.
    repeat (3) send_tick(1'b0, 1'b0);
    // Resync edge, held, then released.
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    // A rising clock captures a period, clock held high, then low, then rising again.
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    // Clock and resync rising together.
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    // Clock dropout so the internal beat keeps going.
    repeat (8) send_tick(1'b0, 1'b0);
    drain();

    widths[0] = 8'd0;
    widths[1] = 8'd255;
    widths[2] = 8'd1;
    widths[3] = 8'd3;
    widths[4] = 8'd2;
    widths[5] = 8'($urandom_range(4, 20));
    widths[6] = MIN_PW_RESET;
    widths[7] = 8'($urandom_range(0, 255));

    foreach (widths[p]) begin
      write_min_width(widths[p]);
      // One phase runs without any idling and with the long receiver hold-off.
      gaps_on = (p != 3);
      if (p == 3) hold_req = 1'b1;
      run_clock_phase(180);
      drain();
    end
    gaps_on = 1'b1;

    repeat (SETTLE) @(posedge clk);
    if (sb.expected_levels.size() != 0)
      sb.report_mismatch("ticks left without a level request");
    if (sb.mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule
